// ===== sv/ghp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghp_pkg
// Symbol codes and onset lookup for German hyphenation point detection.
// ----------------------------------------------------------------------------
package ghp_pkg;

    typedef logic [4:0] t_sym;

    localparam t_sym SYM_A     = 5'd1;
    localparam t_sym SYM_OTHER = 5'd31;
    localparam t_sym SYM_SZ    = 5'd30;

    function automatic t_sym lt(input byte c);
        lt = t_sym'(c - 8'd96);
    endfunction

    function automatic t_sym fold(input logic [20:0] cp);
        if (cp >= 21'h61 && cp <= 21'h7A)      fold = t_sym'(cp - 21'h60);
        else if (cp >= 21'h41 && cp <= 21'h5A) fold = t_sym'(cp - 21'h40);
        else if (cp == 21'hE4 || cp == 21'hC4) fold = 5'd27;
        else if (cp == 21'hF6 || cp == 21'hD6) fold = 5'd28;
        else if (cp == 21'hFC || cp == 21'hDC) fold = 5'd29;
        else if (cp == 21'hDF || cp == 21'h1E9E) fold = SYM_SZ;
        else fold = SYM_OTHER;
    endfunction

    function automatic logic is_vowel(input t_sym s);
        is_vowel = (s == lt("a")) || (s == lt("e")) || (s == lt("i")) ||
                   (s == lt("o")) || (s == lt("u")) || (s == lt("y")) ||
                   (s == 5'd27) || (s == 5'd28) || (s == 5'd29);
    endfunction

    function automatic logic insep(input t_sym a, input t_sym b);
        insep = (a == lt("c") && b == lt("h")) || (a == lt("c") && b == lt("k")) ||
                (a == lt("p") && b == lt("h")) || (a == lt("q") && b == lt("u")) ||
                (a == lt("t") && b == lt("z"));
    endfunction

    function automatic logic on1(input t_sym a);
        on1 = (a >= lt("b") && a <= lt("d")) || (a >= lt("f") && a <= lt("h")) ||
              (a >= lt("j") && a <= lt("n")) || (a >= lt("p") && a <= lt("t")) ||
              a == lt("v") || a == lt("w") || a == lt("z");
    endfunction

    function automatic logic p2(input t_sym a, input t_sym b, input byte x, input byte y);
        p2 = (a == lt(x)) && (b == lt(y));
    endfunction

    function automatic logic on2(input t_sym a, input t_sym b);
        on2 = p2(a, b, "c", "h") || p2(a, b, "p", "f") || p2(a, b, "p", "h") ||
              p2(a, b, "q", "u") || p2(a, b, "s", "p") || p2(a, b, "s", "t") ||
              p2(a, b, "s", "k") || p2(a, b, "k", "l") || p2(a, b, "k", "n") ||
              p2(a, b, "k", "r") || p2(a, b, "p", "l") || p2(a, b, "p", "r") ||
              p2(a, b, "t", "r") || p2(a, b, "d", "r") || p2(a, b, "g", "r") ||
              p2(a, b, "g", "l") || p2(a, b, "b", "r") || p2(a, b, "b", "l") ||
              p2(a, b, "f", "r") || p2(a, b, "f", "l") || p2(a, b, "t", "h");
    endfunction

    function automatic logic on3(input t_sym a, input t_sym b, input t_sym c);
        on3 = (a == lt("s") && b == lt("c") && c == lt("h")) ||
              (a == lt("s") && b == lt("p") && c == lt("r")) ||
              (a == lt("s") && b == lt("p") && c == lt("l")) ||
              (a == lt("s") && b == lt("t") && c == lt("r"));
    endfunction

    function automatic logic on4(input t_sym a, input t_sym b, input t_sym c, input t_sym d);
        on4 = (a == lt("s") && b == lt("c") && c == lt("h")) &&
              (d == lt("l") || d == lt("m") || d == lt("n") || d == lt("r") ||
               d == lt("w"));
    endfunction

endpackage

// ===== sv/german_hyphenation_points.sv =====
// ----------------------------------------------------------------------------
// german_hyphenation_points
// Decodes UTF-8 bytes of a word and reports German hyphenation break offsets.
// ----------------------------------------------------------------------------
// Each accepted byte's result item is registered and shown in the next cycle.
// Throughput: one byte per cycle while o_stall is low; the cluster tracker updates on every accepted byte.
// The output register refills in the cycle it is taken, so stalls only
// hold the input while the result waits.
// Reset: synchronous active low; clears decoder and cluster state.
module german_hyphenation_points #(
    parameter int MAX_WORD_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    input  logic       i_word_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_hyphen_found,
    output logic [7:0] o_hyphen_pos,
    output logic       o_word_done
);
    localparam int IW = $clog2(MAX_WORD_BYTES + 1);
    localparam int PW = (IW > 8) ? IW : 8;

    logic [IW-1:0]     r_idx, n_idx;
    logic [20:0]       r_acc, n_acc;
    logic [1:0]        r_pend, n_pend;
    logic [PW-1:0]     r_cs, n_cs;
    logic              r_vs, n_vs;
    logic [2:0]        r_len, n_len;
    ghp_pkg::t_sym     r_hd [3];
    ghp_pkg::t_sym     n_hd [3];
    ghp_pkg::t_sym     r_tl [4];
    ghp_pkg::t_sym     n_tl [4];
    logic [PW-1:0]     r_csb, n_csb;
    logic [PW-1:0]     r_tp [4];
    logic [PW-1:0]     n_tp [4];
    logic              r_ov, r_f, r_d;
    logic [7:0]        r_p;

    logic              acc_in, done_c, fnd;
    logic [20:0]       cp;
    logic [PW-1:0]     brk, pos;
    ghp_pkg::t_sym     s;

    assign o_stall = r_ov && i_stall;
    assign acc_in  = i_valid && !o_stall;

    always_comb begin
        n_idx = r_idx; n_acc = r_acc; n_pend = r_pend; n_cs = r_cs; n_vs = r_vs;
        n_len = r_len; n_hd = r_hd; n_tl = r_tl; n_csb = r_csb; n_tp = r_tp;
        cp = '0; done_c = 1'b0; fnd = 1'b0; pos = '0; brk = '0;
        if (r_pend != 2'd0 && i_byte_in[7:6] == 2'b10) begin
            n_acc = {r_acc[14:0], i_byte_in[5:0]};
            n_pend = r_pend - 2'd1;
            if (r_pend == 2'd1) begin
                cp = n_acc; done_c = 1'b1;
            end
        end else begin
            n_cs = PW'(r_idx);
            n_pend = 2'd0;
            if (!i_byte_in[7]) begin
                cp = 21'(i_byte_in); done_c = 1'b1;
            end else if (i_byte_in[7:5] == 3'b110) begin
                n_acc = 21'(i_byte_in[4:0]); n_pend = 2'd1;
            end else if (i_byte_in[7:4] == 4'b1110) begin
                n_acc = 21'(i_byte_in[3:0]); n_pend = 2'd2;
            end else if (i_byte_in[7:3] == 5'b11110) begin
                n_acc = 21'(i_byte_in[2:0]); n_pend = 2'd3;
            end else begin
                cp = '1; done_c = 1'b1;
            end
        end
        if (32'(r_idx) < MAX_WORD_BYTES) n_idx = r_idx + IW'(1);
        s = ghp_pkg::fold(cp);
        if (r_len >= 3'd3 && r_hd[0] == ghp_pkg::lt("s") && r_hd[1] == ghp_pkg::lt("c")
            && r_hd[2] == ghp_pkg::lt("h"))
            brk = r_csb;
        else if (r_len == 3'd2 && ghp_pkg::insep(r_tl[2], r_tl[3]))
            brk = n_cs;
        else if ((r_len == 3'd1 && ghp_pkg::on1(r_tl[3])) ||
                 (r_len == 3'd2 && ghp_pkg::on2(r_tl[2], r_tl[3])) ||
                 (r_len == 3'd3 && ghp_pkg::on3(r_tl[1], r_tl[2], r_tl[3])) ||
                 (r_len == 3'd4 && ghp_pkg::on4(r_tl[0], r_tl[1], r_tl[2], r_tl[3])))
            brk = r_csb;
        else if (r_len >= 3'd5 && ghp_pkg::on4(r_tl[0], r_tl[1], r_tl[2], r_tl[3]))
            brk = r_tp[0];
        else if (r_len >= 3'd4 && ghp_pkg::on3(r_tl[1], r_tl[2], r_tl[3]))
            brk = r_tp[1];
        else if (r_len >= 3'd3 && ghp_pkg::on2(r_tl[2], r_tl[3]))
            brk = r_tp[2];
        else if (r_len >= 3'd2 && ghp_pkg::on1(r_tl[3]))
            brk = r_tp[3];
        else if (r_len == 3'd1)
            brk = r_csb;
        else if (r_len == 3'd2)
            brk = r_tp[3];
        else
            brk = ghp_pkg::insep(r_tl[2], r_tl[3]) ? r_tp[2] : r_tp[3];
        if (done_c) begin
            if (ghp_pkg::is_vowel(s)) begin
                if (r_vs && r_len != 3'd0) begin
                    if (32'(brk) < MAX_WORD_BYTES && 32'(brk) <= 255) begin
                        fnd = 1'b1; pos = brk;
                    end
                end
                n_vs = 1'b1;
                n_len = 3'd0;
            end else if (r_vs) begin
                if (r_len == 3'd0) n_csb = n_cs;
                if (r_len < 3'd3) n_hd[r_len[1:0]] = s;
                n_tl = '{r_tl[1], r_tl[2], r_tl[3], s};
                n_tp = '{r_tp[1], r_tp[2], r_tp[3], n_cs};
                if (r_len < 3'd5) n_len = r_len + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc_in && i_word_end)) begin
            r_idx <= '0; r_acc <= '0; r_pend <= '0; r_cs <= '0; r_vs <= 1'b0;
            r_len <= '0; r_csb <= '0;
            r_hd <= '{default: '0}; r_tl <= '{default: '0}; r_tp <= '{default: '0};
        end else if (acc_in) begin
            r_idx <= n_idx; r_acc <= n_acc; r_pend <= n_pend; r_cs <= n_cs;
            r_vs <= n_vs; r_len <= n_len; r_hd <= n_hd; r_tl <= n_tl;
            r_csb <= n_csb; r_tp <= n_tp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (acc_in) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_f <= fnd; r_p <= pos[7:0]; r_d <= i_word_end;
        end
    end

    assign o_valid        = r_ov;
    assign o_hyphen_found = r_f;
    assign o_hyphen_pos   = r_p;
    assign o_word_done    = r_d;

`ifndef NO_ASSERTIONS
    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_len <= 3'd5)
        else $error("cluster length out of range");
    a_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in && i_word_end |=> r_idx == '0 && !r_vs && r_pend == 2'd0)
        else $error("state not cleared after word end");
    a_len_vs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != 3'd0 |-> r_vs)
        else $error("cluster without left vowel");
    a_pos0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hyphen_found |-> o_hyphen_pos == 8'd0)
        else $error("position without break");
`endif
endmodule

// ===== sim/german_hyphenation_points_test.sv =====
// ----------------------------------------------------------------------------
// german_hyphenation_points_test
// Drives UTF-8 words into the hyphenation block with random gaps and stalls,
// predicts every break offset and compares each result item in order.
// ----------------------------------------------------------------------------
module german_hyphenation_points_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_LIMIT = 256;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic       found;
        logic [7:0] pos;
        logic       done;
    } t_break_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_byte_in = 8'd0;
    logic       i_word_end = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_hyphen_found;
    logic [7:0] o_hyphen_pos;
    logic       o_word_done;

    german_hyphenation_points #(.MAX_WORD_BYTES(WORD_LIMIT)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_byte_in(i_byte_in), .i_word_end(i_word_end), .o_valid(o_valid),
        .i_stall(i_stall), .o_hyphen_found(o_hyphen_found),
        .o_hyphen_pos(o_hyphen_pos), .o_word_done(o_word_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_byte_item  pending_bytes[$];
    t_break_item expected_breaks[$];
    int mismatches = 0;
    int bytes_sent = 0;
    int breaks_seen = 0;
    int words_sent = 0;
    bit stim_done = 0;

    // predictor state
    int             p_index, p_accum, p_pending, p_char_start, p_clen, p_cstart;
    bit             p_vseen;
    ghp_pkg::t_sym  p_head[3];
    ghp_pkg::t_sym  p_tail[4];
    int             p_tpos[4];

    function automatic ghp_pkg::t_sym sym_of(int c);
        return ghp_pkg::t_sym'(c - 96);
    endfunction

    function automatic bit pair_fixed(ghp_pkg::t_sym a, ghp_pkg::t_sym b);
        return (a == sym_of("c") && (b == sym_of("h") || b == sym_of("k"))) ||
               (a == sym_of("p") && b == sym_of("h")) ||
               (a == sym_of("q") && b == sym_of("u")) ||
               (a == sym_of("t") && b == sym_of("z"));
    endfunction

    function automatic bit onset_match(ghp_pkg::t_sym s[4], int n);
        string onsets[49] = '{"b","c","d","f","g","h","j","k","l","m","n","p","q",
            "r","s","t","v","w","z","ch","pf","ph","qu","sch","sp","st","sk","kl",
            "kn","kr","pl","pr","tr","dr","gr","gl","br","bl","fr","fl","schl",
            "schm","schn","schr","schw","spr","spl","str","th"};
        bit same;
        foreach (onsets[k]) begin
            if (onsets[k].len() == n) begin
                same = 1;
                for (int i = 0; i < n; i++)
                    if (s[4 - n + i] != sym_of(onsets[k][i])) same = 0;
                if (same) return 1;
            end
        end
        return 0;
    endfunction

    function automatic ghp_pkg::t_sym fold_cp(int cp);
        if (cp >= 'h61 && cp <= 'h7A) return ghp_pkg::t_sym'(cp - 'h60);
        if (cp >= 'h41 && cp <= 'h5A) return ghp_pkg::t_sym'(cp - 'h40);
        if (cp == 'hE4 || cp == 'hC4) return 5'd27;
        if (cp == 'hF6 || cp == 'hD6) return 5'd28;
        if (cp == 'hFC || cp == 'hDC) return 5'd29;
        if (cp == 'hDF || cp == 'h1E9E) return ghp_pkg::SYM_SZ;
        return ghp_pkg::SYM_OTHER;
    endfunction

    function automatic bit vowel_sym(ghp_pkg::t_sym s);
        return s == sym_of("a") || s == sym_of("e") || s == sym_of("i") ||
               s == sym_of("o") || s == sym_of("u") || s == sym_of("y") ||
               s == 5'd27 || s == 5'd28 || s == 5'd29;
    endfunction

    function automatic int break_offset(int end_byte);
        int n = p_clen;
        int lmax;
        if (n >= 3 && p_head[0] == sym_of("s") && p_head[1] == sym_of("c") &&
            p_head[2] == sym_of("h")) return p_cstart;
        if (n == 2 && pair_fixed(p_tail[2], p_tail[3])) return end_byte;
        if (n <= 4 && onset_match(p_tail, n)) return p_cstart;
        if (n >= 2) begin
            lmax = (n - 1 > 4) ? 4 : n - 1;
            for (int len = lmax; len >= 1; len--)
                if (onset_match(p_tail, len)) return p_tpos[4 - len];
        end
        if (n == 1) return p_cstart;
        if (n == 2) return p_tpos[3];
        return pair_fixed(p_tail[2], p_tail[3]) ? p_tpos[2] : p_tpos[3];
    endfunction

    function automatic void clear_word();
        p_index = 0; p_accum = 0; p_pending = 0; p_char_start = 0;
        p_vseen = 0; p_clen = 0; p_cstart = 0;
        for (int i = 0; i < 3; i++) p_head[i] = '0;
        for (int i = 0; i < 4; i++) begin
            p_tail[i] = '0;
            p_tpos[i] = 0;
        end
    endfunction

    function automatic t_break_item predict_break(t_byte_item it);
        t_break_item r;
        int b = it.data;
        int cp = 0;
        int pos = 0;
        bit got = 0;
        ghp_pkg::t_sym s;
        r = '0;
        if (p_pending > 0 && (b & 'hC0) == 'h80) begin
            p_accum = ((p_accum << 6) | (b & 'h3F)) & 'h1FFFFF;
            p_pending--;
            if (p_pending == 0) begin
                cp = p_accum;
                got = 1;
            end
        end else begin
            p_char_start = p_index;
            p_pending = 0;
            if (b < 'h80) begin
                cp = b;
                got = 1;
            end else if (b >= 'hC0 && b <= 'hDF) begin
                p_accum = b & 'h1F; p_pending = 1;
            end else if (b >= 'hE0 && b <= 'hEF) begin
                p_accum = b & 'h0F; p_pending = 2;
            end else if (b >= 'hF0 && b <= 'hF7) begin
                p_accum = b & 'h07; p_pending = 3;
            end else begin
                cp = -1;
                got = 1;
            end
        end
        if (p_index < WORD_LIMIT) p_index++;
        if (got) begin
            s = fold_cp(cp);
            if (vowel_sym(s)) begin
                if (p_vseen && p_clen > 0) begin
                    pos = break_offset(p_char_start);
                    if (pos < WORD_LIMIT && pos <= 255) r.found = 1;
                    else pos = 0;
                end
                p_vseen = 1;
                p_clen = 0;
            end else if (p_vseen) begin
                if (p_clen == 0) p_cstart = p_char_start;
                if (p_clen < 3) p_head[p_clen] = s;
                for (int i = 0; i < 3; i++) begin
                    p_tail[i] = p_tail[i + 1];
                    p_tpos[i] = p_tpos[i + 1];
                end
                p_tail[3] = s;
                p_tpos[3] = p_char_start;
                if (p_clen < 5) p_clen++;
            end
        end
        r.pos = pos[7:0];
        r.done = it.last;
        if (it.last) clear_word();
        return r;
    endfunction

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_word(string w);
        for (int i = 0; i < w.len(); i++)
            pending_bytes.insert(pending_bytes.size(),
                                 t_byte_item'{w[i], i == w.len() - 1});
    endtask

    function automatic string random_char();
        string cons = "bcdfghjklmnpqrstvwxzs";
        string vow = "aeiouy";
        string s;
        int r = $urandom_range(0, 99);
        if (r < 40) s = string'(cons[$urandom_range(0, cons.len() - 1)]);
        else if (r < 65) s = string'(vow[$urandom_range(0, 5)]);
        else if (r < 70) s = "sch";
        else if (r < 74) begin
            string pr[6] = '{"ch", "ck", "ph", "qu", "tz", "str"};
            s = pr[$urandom_range(0, 5)];
        end else if (r < 84) begin
            byte um[8] = '{8'hA4, 8'hB6, 8'hBC, 8'h9F, 8'h84, 8'h96, 8'h9C, 8'hA9};
            s = string'({8'hC3, um[$urandom_range(0, 7)]});
        end else if (r < 87) s = string'({8'hE1, 8'hBA, 8'h9E});
        else if (r < 90) s = string'({8'hF0, 8'h9F, 8'h98, 8'h80});
        else if (r < 94) s = string'(byte'($urandom_range(65, 90)));
        else s = string'(byte'($urandom_range(0, 255)));
        return s;
    endfunction

    task automatic push_bytes(byte unsigned bs[$]);
        foreach (bs[i])
            pending_bytes.insert(pending_bytes.size(),
                                 t_byte_item'{bs[i], i == bs.size() - 1});
    endtask

    // held input as seen at the last rising edge
    logic o_stall_q = 1'b0;

    // driver
    int drv_gap = 0;
    int stall_run = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall_q) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    i_valid <= 1'b1;
                    {i_byte_in, i_word_end} <= pending_bytes.pop_front();
                    drv_gap <= gap_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (stall_run > 0) begin
                stall_run <= stall_run - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 99) < 30) stall_run <= gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        o_stall_q <= i_rst_n && i_valid && o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_breaks.insert(expected_breaks.size(),
                                       predict_break('{i_byte_in, i_word_end}));
                bytes_sent++;
                if (i_word_end) words_sent++;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_break_item got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_hyphen_found, o_hyphen_pos, o_word_done};
            if (o_hyphen_found) breaks_seen++;
            if (expected_breaks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
            end else begin
                want = expected_breaks.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected found=%0b pos=%0d done=%0b,",
                                  " got found=%0b pos=%0d done=%0b"},
                                 want.found, want.pos, want.done,
                                 got.found, got.pos, got.done);
                end
            end
        end
    end

    initial begin
        string w;
        byte unsigned bs[$];
        clear_word();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        push_word("a");
        push_word("abe");
        push_word("asche");
        push_word("backe");
        push_word("katze");
        push_word("apfel");
        push_word("ostrich");
        push_word("erbse");
        push_word("ankle");
        push_word("xyzzy");
        push_word("ARBEIT");
        push_word("Ende!");
        push_word(string'({"M", 8'hC3, 8'hBC, "ller"}));
        push_word(string'({"gro", 8'hE1, 8'hBA, 8'h9E, "e"}));
        push_word(string'({"a", 8'hFF, "e"}));
        push_word(string'({"a", 8'h80, "o"}));
        push_word(string'({"a", 8'hC3, "ne"}));
        push_word(string'({"e", 8'hF0, 8'h9F}));
        push_word(string'({"a", 8'hC1, 8'hA1, "b", 8'hE0, 8'h81, 8'hA5}));
        bs = '{8'h00, "a", 8'h7F, "e"};
        push_bytes(bs);
        bs.delete();
        for (int i = 0; i < 300; i++) bs.insert(bs.size(), (i % 2) ? "b" : "a");
        push_bytes(bs);

        while (bytes_sent + pending_bytes.size() < 1900) begin
            w = "";
            repeat ($urandom_range(1, 14)) w = {w, random_char()};
            push_word(w);
            wait (pending_bytes.size() < 40);
        end
        wait (pending_bytes.size() == 0 && !i_valid);
        wait (expected_breaks.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("checked %0d bytes in %0d words, %0d breaks reported", bytes_sent,
                 words_sent, breaks_seen);
        if (mismatches == 0 && expected_breaks.size() == 0) begin
            $display("german_hyphenation_points_test passed");
        end else begin
            $display("german_hyphenation_points_test failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("german_hyphenation_points_test failed");
        $finish;
    end
endmodule
